// ===== rtl/sha1_message_digest_defines.svh =====
// Assertion macros shared by the SHA-1 RTL.
// Each expects aclk and aresetn in the scope where it is used.
`ifndef SHA1_MESSAGE_DIGEST_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_DEFINES_SVH

// same-cycle implication
`define SHA1_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SHA1_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sha1_pkg.sv =====
package sha1_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_beat_t;

    // sequencer -> compression unit
    typedef struct packed {
        logic shift_byte;
        logic start;
        logic restart;
    } core_ctrl_t;

    // compression unit -> sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    localparam logic [4:0][31:0] INIT_CHAIN = {
        32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    localparam logic [31:0] K_ROUND0 = 32'h5a827999;
    localparam logic [31:0] K_ROUND1 = 32'h6ed9eba1;
    localparam logic [31:0] K_ROUND2 = 32'h8f1bbcdc;
    localparam logic [31:0] K_ROUND3 = 32'hca62c1d6;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [5:0] BLOCK_LAST = 6'd63;
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [2:0] WORD_LAST  = 3'd4;

    localparam logic [6:0] ROUND_Q1 = 7'd20;
    localparam logic [6:0] ROUND_Q2 = 7'd40;
    localparam logic [6:0] ROUND_Q3 = 7'd60;

    function automatic logic [31:0] round_f(input logic [6:0] rnd,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
        logic [31:0] f;
        if (rnd < ROUND_Q1) begin
            f = (b & c) | (~b & d);
        end else if (rnd < ROUND_Q2) begin
            f = b ^ c ^ d;
        end else if (rnd < ROUND_Q3) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] rnd);
        logic [31:0] k;
        if (rnd < ROUND_Q1) begin
            k = K_ROUND0;
        end else if (rnd < ROUND_Q2) begin
            k = K_ROUND1;
        end else if (rnd < ROUND_Q3) begin
            k = K_ROUND2;
        end else begin
            k = K_ROUND3;
        end
        return k;
    endfunction

endpackage

// ===== rtl/sha1_core.sv =====
`include "sha1_message_digest_defines.svh"

module sha1_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sha1_pkg::core_ctrl_t ctrl,
    input  logic [7:0]           byte_in,
    output sha1_pkg::core_stat_t stat,
    output logic [4:0][31:0]     chain
);

    // Message window: bytes shift in at the bottom; during rounds the top
    // word is W[t] and the next schedule word shifts in at the bottom.
    logic [511:0]      msg_reg, msg_next;
    logic [4:0][31:0]  var_reg, var_next;
    logic [4:0][31:0]  chain_reg, chain_next;
    logic [6:0]        round_reg, round_next;
    logic              busy_reg, busy_next;
    logic              fin_reg, fin_next;

    logic [31:0] w0, w2, w8, w13, mix, sched, temp;
    logic [31:0] a, b, c, d, e;

    assign w0  = msg_reg[511:480];
    assign w2  = msg_reg[447:416];
    assign w8  = msg_reg[255:224];
    assign w13 = msg_reg[95:64];
    assign mix   = w13 ^ w8 ^ w2 ^ w0;
    assign sched = {mix[30:0], mix[31]};

    assign a = var_reg[0];
    assign b = var_reg[1];
    assign c = var_reg[2];
    assign d = var_reg[3];
    assign e = var_reg[4];

    assign temp = {a[26:0], a[31:27]} + sha1_pkg::round_f(round_reg, b, c, d) + e
                  + sha1_pkg::round_k(round_reg) + w0;

    always_comb begin
        msg_next   = msg_reg;
        var_next   = var_reg;
        chain_next = chain_reg;
        round_next = round_reg;
        busy_next  = busy_reg;
        fin_next   = fin_reg;

        if (ctrl.restart) begin
            chain_next = sha1_pkg::INIT_CHAIN;
        end
        if (ctrl.shift_byte) begin
            msg_next = {msg_reg[503:0], byte_in};
        end

        if (ctrl.start) begin
            var_next   = chain_reg;
            round_next = '0;
            busy_next  = 1'b1;
            fin_next   = 1'b0;
        end else if (busy_reg && !fin_reg) begin
            var_next[4] = d;
            var_next[3] = c;
            var_next[2] = {b[1:0], b[31:2]};
            var_next[1] = a;
            var_next[0] = temp;
            msg_next    = {msg_reg[479:0], sched};
            round_next  = round_reg + 7'd1;
            if (round_reg == sha1_pkg::ROUND_LAST) begin
                fin_next = 1'b1;
            end
        end else if (fin_reg) begin
            for (int i = 0; i < 5; i++) begin
                chain_next[i] = chain_reg[i] + var_reg[i];
            end
            fin_next  = 1'b0;
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= sha1_pkg::INIT_CHAIN;
            round_reg <= '0;
            busy_reg  <= 1'b0;
            fin_reg   <= 1'b0;
        end else begin
            chain_reg <= chain_next;
            round_reg <= round_next;
            busy_reg  <= busy_next;
            fin_reg   <= fin_next;
        end
    end

    always_ff @(posedge aclk) begin
        msg_reg <= msg_next;
        var_reg <= var_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = fin_reg;
    assign chain     = chain_reg;

    `SHA1_ASSERT_NOW(a_no_load_while_busy, busy_reg, !ctrl.shift_byte && !ctrl.start,
        "byte load or start while compressing")
    `SHA1_ASSERT_NEXT(a_fin_after_last_round,
        busy_reg && !fin_reg && round_reg == sha1_pkg::ROUND_LAST, fin_reg && busy_reg,
        "chain add did not follow last round")
    `SHA1_ASSERT_NOW(a_round_in_range, busy_reg && !fin_reg,
        round_reg <= sha1_pkg::ROUND_LAST, "round counter past last round")

endmodule

// ===== rtl/sha1_message_digest.sv =====
`include "sha1_message_digest_defines.svh"

// SHA-1 digest of a byte stream.
// Input channel s_*: one beat carries an optional byte (byte_present) and an
// optional end mark (end_of_message). A byte and an end in the same beat mean
// the byte is the last one of the message.
// Output channel m_*: after an end mark the block pads the message and sends
// the digest as five beats, word_index 0..4, last_word set on the fifth.
// A byte beat that does not fill a block shifts the byte in and counts it. A byte that
// fills the 64-byte block starts an 80-round compression, one round per
// cycle in a single round unit, then the chain add; s_ready is low through
// the rounds and the chain add. An end mark is followed by the pad bytes
// (up to 64, or 72 when the length spills into a second block) and one or
// two compressions, then the digest words stream out at one per cycle while
// m_ready is high.
// s_ready is low from an end mark until the last digest word is taken; a
// stalled receiver simply holds the block in that state, the word held.
// Reset (aresetn low, synchronous) loads the initial chaining value and
// clears the byte and bit counts; the block then waits for a new message.
module sha1_message_digest (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sha1_pkg::in_beat_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output sha1_pkg::out_beat_t m_item
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PAD  = 4'b0010,
        ST_HASH = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    state_t      ret_reg, ret_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic        pad_sent_reg, pad_sent_next;
    logic        len_phase_reg, len_phase_next;
    logic [2:0]  word_reg, word_next;

    sha1_pkg::core_ctrl_t core_ctrl;
    sha1_pkg::core_stat_t core_stat;
    logic [7:0]           core_byte;
    logic [4:0][31:0]     chain;

    logic        accept_in;
    logic        in_len;
    logic        block_full;
    logic [63:0] len_sh;
    logic [7:0]  pad_byte;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept_in  = s_valid && s_ready;
    assign block_full = (fill_reg == sha1_pkg::BLOCK_LAST);
    assign in_len     = len_phase_reg || (pad_sent_reg && fill_reg == sha1_pkg::LEN_OFFSET);
    // offset 56 sends the top length byte, offset 63 the bottom one
    assign len_sh     = bits_reg >> {~fill_reg[2:0], 3'b000};
    assign pad_byte   = !pad_sent_reg ? sha1_pkg::PAD_BYTE : (in_len ? len_sh[7:0] : 8'h00);
    assign core_byte  = (state_reg == ST_IDLE) ? s_item.data_byte : pad_byte;

    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        fill_next      = fill_reg;
        bits_next      = bits_reg;
        pad_sent_next  = pad_sent_reg;
        len_phase_next = len_phase_reg;
        word_next      = word_reg;
        core_ctrl      = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept_in) begin
                    if (s_item.byte_present) begin
                        core_ctrl.shift_byte = 1'b1;
                        fill_next = fill_reg + 6'd1;
                        bits_next = bits_reg + 64'd8;
                        if (block_full) begin
                            core_ctrl.start = 1'b1;
                            state_next      = ST_HASH;
                            ret_next        = s_item.end_of_message ? ST_PAD : ST_IDLE;
                        end else if (s_item.end_of_message) begin
                            state_next = ST_PAD;
                        end
                    end else if (s_item.end_of_message) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                core_ctrl.shift_byte = 1'b1;
                fill_next     = fill_reg + 6'd1;
                pad_sent_next = 1'b1;
                if (in_len) begin
                    len_phase_next = 1'b1;
                end
                if (block_full) begin
                    core_ctrl.start = 1'b1;
                    state_next      = ST_HASH;
                    ret_next        = in_len ? ST_OUT : ST_PAD;
                end
            end
            ST_HASH: begin
                if (core_stat.done) begin
                    state_next = ret_reg;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (word_reg == sha1_pkg::WORD_LAST) begin
                        core_ctrl.restart = 1'b1;
                        state_next     = ST_IDLE;
                        word_next      = '0;
                        fill_next      = '0;
                        bits_next      = '0;
                        pad_sent_next  = 1'b0;
                        len_phase_next = 1'b0;
                    end else begin
                        word_next = word_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            fill_reg      <= '0;
            bits_reg      <= '0;
            pad_sent_reg  <= 1'b0;
            len_phase_reg <= 1'b0;
            word_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            fill_reg      <= fill_next;
            bits_reg      <= bits_next;
            pad_sent_reg  <= pad_sent_next;
            len_phase_reg <= len_phase_next;
            word_reg      <= word_next;
        end
    end

    sha1_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (core_ctrl),
        .byte_in (core_byte),
        .stat    (core_stat),
        .chain   (chain)
    );

    assign m_valid            = (state_reg == ST_OUT);
    assign m_item.digest_word = chain[word_reg];
    assign m_item.word_index  = word_reg;
    assign m_item.last_word   = (word_reg == sha1_pkg::WORD_LAST);

    `SHA1_ASSERT_NOW(a_ready_core_idle, s_ready, !core_stat.busy,
        "input ready while compression runs")
    `SHA1_ASSERT_NOW(a_out_core_idle, m_valid, !core_stat.busy && !s_ready,
        "digest shown while core busy or input open")
    `SHA1_ASSERT_NEXT(a_ready_after_last, m_valid && m_ready && m_item.last_word,
        s_ready && fill_reg == 6'd0 && bits_reg == 64'd0,
        "block not back to a fresh message after last word")

endmodule
